// ----- hdl/cubic_bezier_easing_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cubic-bezier easing core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EASING_CORE_DEFINES_SVH
`define CUBIC_BEZIER_EASING_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CBE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cubic bezier easing core: same-cycle check failed");
`define CBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cubic bezier easing core: next-cycle check failed");
`else
`define CBE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CBE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/cbe_pkg.sv -----
// ----------------------------------------------------------------------------
// cbe_pkg
// Types, constants and the fixed-point lerp shared by the easing core.
// ----------------------------------------------------------------------------
package cbe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VW        = 21;  // internal signed value width
  localparam int TW        = 17;  // curve parameter width, Q1.16 for 0 to 1.0
  localparam int RW        = 19;  // ratio and factor width
  localparam int IW        = 3;   // config index width

  typedef logic signed [VW-1:0] val_t;
  typedef logic [TW-1:0]        tpar_t;

  localparam tpar_t ONE_T = tpar_t'(1) << FRAC_BITS;
  localparam val_t  ONE_V = val_t'(1) << FRAC_BITS;

  localparam logic [IW-1:0] CFG_FIRST_X  = 3'd0;
  localparam logic [IW-1:0] CFG_FIRST_Y  = 3'd1;
  localparam logic [IW-1:0] CFG_SECOND_X = 3'd2;
  localparam logic [IW-1:0] CFG_SECOND_Y = 3'd3;
  localparam logic [IW-1:0] CFG_HOLD     = 3'd4;

  typedef enum logic [1:0] {
    KIND_CURVE,
    KIND_HOLD,
    KIND_LOW,
    KIND_HIGH
  } kind_t;

  typedef struct packed {
    logic                   valid;
    kind_t                  kind;
    logic signed [RW-1:0]   ratio;
    tpar_t                  lo;
    tpar_t                  hi;
  } item_t;

  // a + floor((b - a) * t / ONE)
  function automatic val_t lerp(val_t a, val_t b, tpar_t t);
    logic signed [VW:0]       diff;
    logic signed [VW+TW+1:0]  prod;
    val_t                     step;
    diff = $signed({b[VW-1], b}) - $signed({a[VW-1], a});
    prod = diff * $signed({1'b0, t});
    step = prod[FRAC_BITS+VW-1:FRAC_BITS];
    return a + step;
  endfunction

endpackage

// ----- hdl/cbe_if.sv -----
// ----------------------------------------------------------------------------
// cbe_in_if / cbe_out_if
// Valid/ready channels for ratio samples and easing results.
// ----------------------------------------------------------------------------
interface cbe_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [18:0]       ratio;

  modport source (output valid, output ratio, input ready);
  modport sink   (input valid, input ratio, output ready);
endinterface

interface cbe_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [18:0]       factor;
  logic [16:0]              curve_t;

  modport source (output valid, output factor, output curve_t, input ready);
  modport sink   (input valid, input factor, input curve_t, output ready);
endinterface

// ----- hdl/cbe_cubic.sv -----
// ----------------------------------------------------------------------------
// cbe_cubic
// Three-stage de Casteljau evaluator of a cubic from 0 through p1, p2 to one.
// ----------------------------------------------------------------------------
module cbe_cubic (
  input  logic           clk,
  input  logic           en,
  input  cbe_pkg::val_t  p1,
  input  cbe_pkg::val_t  p2,
  input  cbe_pkg::tpar_t t,
  output cbe_pkg::val_t  value
);

  cbe_pkg::val_t  a, b, c, d, e;
  cbe_pkg::tpar_t t1, t2;

  // first level: three independent lerps
  always_ff @(posedge clk) begin
    if (en) begin
      a  <= cbe_pkg::lerp('0, p1, t);
      b  <= cbe_pkg::lerp(p1, p2, t);
      c  <= cbe_pkg::lerp(p2, cbe_pkg::ONE_V, t);
      t1 <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d  <= cbe_pkg::lerp(a, b, t1);
      e  <= cbe_pkg::lerp(b, c, t1);
      t2 <= t1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= cbe_pkg::lerp(d, e, t2);
    end
  end

endmodule

// ----- hdl/cbe_step.sv -----
// ----------------------------------------------------------------------------
// cbe_step
// One bisection step: evaluate x at the midpoint, then narrow lo or hi.
// ----------------------------------------------------------------------------
module cbe_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  cbe_pkg::val_t  x1,
  input  cbe_pkg::val_t  x2,
  input  cbe_pkg::item_t item_in,
  output cbe_pkg::item_t item_out
);

  localparam int TW = cbe_pkg::TW;

  logic [TW:0]     sum;
  cbe_pkg::tpar_t  mid;
  cbe_pkg::val_t   x_mid;
  cbe_pkg::item_t  item_q [3];
  cbe_pkg::tpar_t  mid_q  [3];
  cbe_pkg::val_t   ratio_v;

  assign sum = {1'b0, item_in.lo} + {1'b0, item_in.hi};
  assign mid = sum[TW:1];

  cbe_cubic u_cubic (
    .clk   (clk),
    .en    (en),
    .p1    (x1),
    .p2    (x2),
    .t     (mid),
    .value (x_mid)
  );

  // carry the item alongside the evaluator
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q[0].valid <= 1'b0;
      item_q[1].valid <= 1'b0;
      item_q[2].valid <= 1'b0;
    end else if (en) begin
      item_q[0] <= item_in;
      item_q[1] <= item_q[0];
      item_q[2] <= item_q[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_q[0] <= mid;
      mid_q[1] <= mid_q[0];
      mid_q[2] <= mid_q[1];
    end
  end

  assign ratio_v = cbe_pkg::val_t'(item_q[2].ratio);

  always_comb begin
    item_out = item_q[2];
    if (x_mid < ratio_v) begin
      item_out.lo = mid_q[2];
    end else begin
      item_out.hi = mid_q[2];
    end
  end

endmodule

// ----- hdl/cubic_bezier_easing_core.sv -----
// Path from sample beat to result beat: entry register, bisection steps, y evaluator, output register.
// Throughput: one sample per cycle while no result is held; every bisection step is its own 3-stage evaluator.
// The whole pipeline advances together, so a held result stalls all stages in place.
// Reset: rst is synchronous, active high; clears valid bits and loads handle defaults.
// ----------------------------------------------------------------------------
// cubic_bezier_easing_core
// Cubic-bezier easing curve: bisect x(t) = ratio, answer with y(t) and t.
// ----------------------------------------------------------------------------
`include "cubic_bezier_easing_core_defines.svh"

module cubic_bezier_easing_core #(
  parameter int BISECT_STEPS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cbe_pkg::IW-1:0]       cfg_index,
  input  logic [18:0]                  cfg_data,
  cbe_in_if.sink                       sample,
  cbe_out_if.source                    result
);

  localparam int FB = cbe_pkg::FRAC_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes must come only while the pipeline is empty,
  // which the block does not enforce; every stage reads them directly.
  // --------------------------------------------------------------------------
  logic [16:0]        first_x, second_x;
  logic signed [18:0] first_y, second_y;
  logic               hold_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_x   <= 17'd21845;
      first_y   <= 19'sd21845;
      second_x  <= 17'd43691;
      second_y  <= 19'sd43691;
      hold_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbe_pkg::CFG_FIRST_X:  first_x   <= cfg_data[16:0];
        cbe_pkg::CFG_FIRST_Y:  first_y   <= cfg_data;
        cbe_pkg::CFG_SECOND_X: second_x  <= cfg_data[16:0];
        cbe_pkg::CFG_SECOND_Y: second_y  <= cfg_data;
        cbe_pkg::CFG_HOLD:     hold_mode <= cfg_data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Saturate handle x to one so x(t) stays monotone; widen all handles.
  cbe_pkg::val_t x1, x2, y1, y2;

  assign x1 = (first_x > cbe_pkg::ONE_T) ? cbe_pkg::ONE_V : cbe_pkg::val_t'({4'b0, first_x});
  assign x2 = (second_x > cbe_pkg::ONE_T) ? cbe_pkg::ONE_V : cbe_pkg::val_t'({4'b0, second_x});
  assign y1 = cbe_pkg::val_t'(first_y);
  assign y2 = cbe_pkg::val_t'(second_y);

  // --------------------------------------------------------------------------
  // Global advance: every stage moves when the output register is free or
  // its beat is being taken.
  // --------------------------------------------------------------------------
  logic           out_valid;
  logic           adv;

  assign adv          = !out_valid || result.ready;
  assign sample.ready = adv;

  // --------------------------------------------------------------------------
  // Input stage: classify the ratio and seed the search interval.
  // --------------------------------------------------------------------------
  cbe_pkg::item_t  entry;
  cbe_pkg::kind_t  kind_in;
  logic signed [18:0] one_r;

  assign one_r = 19'sd1 <<< FB;

  always_comb begin
    if (hold_mode) begin
      kind_in = cbe_pkg::KIND_HOLD;
    end else if (sample.ratio <= 19'sd0) begin
      kind_in = cbe_pkg::KIND_LOW;
    end else if (sample.ratio >= one_r) begin
      kind_in = cbe_pkg::KIND_HIGH;
    end else begin
      kind_in = cbe_pkg::KIND_CURVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (adv) begin
      entry.valid <= sample.valid;
      entry.kind  <= kind_in;
      entry.ratio <= sample.ratio;
      entry.lo    <= '0;
      entry.hi    <= cbe_pkg::ONE_T;
    end
  end

  // --------------------------------------------------------------------------
  // Bisection chain: one step module per step, each three stages deep.
  // --------------------------------------------------------------------------
  cbe_pkg::item_t chain [BISECT_STEPS+1];

  assign chain[0] = entry;

  for (genvar s = 0; s < BISECT_STEPS; s++) begin : g_step
    cbe_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .x1       (x1),
      .x2       (x2),
      .item_in  (chain[s]),
      .item_out (chain[s+1])
    );
  end

  // --------------------------------------------------------------------------
  // y(t) at the final hi, with the item delayed to match.
  // --------------------------------------------------------------------------
  cbe_pkg::item_t found;
  cbe_pkg::val_t  y_val;
  cbe_pkg::item_t y_item [3];

  assign found = chain[BISECT_STEPS];

  cbe_cubic u_y_eval (
    .clk   (clk),
    .en    (adv),
    .p1    (y1),
    .p2    (y2),
    .t     (found.hi),
    .value (y_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      y_item[0].valid <= 1'b0;
      y_item[1].valid <= 1'b0;
      y_item[2].valid <= 1'b0;
    end else if (adv) begin
      y_item[0] <= found;
      y_item[1] <= y_item[0];
      y_item[2] <= y_item[1];
    end
  end

  // --------------------------------------------------------------------------
  // Output register: pick the special-case answer or the curve answer.
  // --------------------------------------------------------------------------
  logic signed [18:0] factor_next, factor_q;
  logic [16:0]        t_next, t_q;
  cbe_pkg::kind_t     kind_q;

  always_comb begin
    case (y_item[2].kind)
      cbe_pkg::KIND_HOLD: begin
        factor_next = (y_item[2].ratio >= one_r) ? one_r : 19'sd0;
        t_next      = '0;
      end
      cbe_pkg::KIND_LOW: begin
        factor_next = 19'sd0;
        t_next      = '0;
      end
      cbe_pkg::KIND_HIGH: begin
        factor_next = one_r;
        t_next      = cbe_pkg::ONE_T;
      end
      default: begin
        factor_next = y_val[18:0];
        t_next      = y_item[2].hi;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= y_item[2].valid;
      factor_q  <= factor_next;
      t_q       <= t_next;
      kind_q    <= y_item[2].kind;
    end
  end

  assign result.valid   = out_valid;
  assign result.factor  = factor_q;
  assign result.curve_t = t_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `CBE_ASSERT_IMPLY(a_ready_follows_output, clk, rst, 1'b1, sample.ready == (!result.valid || result.ready))
  `CBE_ASSERT_IMPLY(a_hold_is_step, clk, rst, result.valid && kind_q == cbe_pkg::KIND_HOLD, result.curve_t == 17'd0 && (result.factor == 19'sd0 || result.factor == one_r))
  `CBE_ASSERT_IMPLY(a_curve_t_in_range, clk, rst, result.valid && kind_q == cbe_pkg::KIND_CURVE, result.curve_t != 17'd0 && result.curve_t <= cbe_pkg::ONE_T)

endmodule
